>>> rtl/shfp_pkg.sv
// Shared constants and field layout for the sync-header frame parser.
// No dependencies; imported by sync_header_frame_parser_core.
`timescale 1ns / 1ps
`default_nettype none

package shfp_pkg;

   // Frame format
   localparam logic [7:0]  SYNC_A          = 8'h40;   // '@'
   localparam logic [7:0]  SYNC_B          = 8'h54;   // 'T'
   localparam logic [7:0]  SERIAL_MOD_MASK = 8'h7F;
   localparam logic [15:0] MAX_DATA        = 16'd2048;

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 11;
   localparam int LENGTH_W  = 12;
   localparam int VERSION_W = 16;
   localparam int CRC_W     = 32;
   localparam int FLAGS_W   = 3;
   localparam int RSP_DATA_W = 128;

   // Result kinds carried on tuser
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_HEADER = 1'b1;

   // Input modes carried on tuser
   localparam logic MODE_BYTE         = 1'b0;
   localparam logic MODE_FORGET_SERIAL = 1'b1;

   // Status flag bit positions
   localparam int FLAG_VERSION  = 0;
   localparam int FLAG_SERIAL   = 1;
   localparam int FLAG_CHECKSUM = 2;

   // Result payload, last field in the lowest bits
   typedef struct packed {
      logic [5:0]           pad;
      logic [FLAGS_W-1:0]   status_flags;
      logic [CRC_W-1:0]     checksum_value;
      logic [BYTE_W-1:0]    transfer_mode;
      logic [BYTE_W-1:0]    command_byte;
      logic [VERSION_W-1:0] feature_address;
      logic [BYTE_W-1:0]    frame_serial;
      logic [LENGTH_W-1:0]  data_length;
      logic [VERSION_W-1:0] sender_version;
      logic [INDEX_W-1:0]   data_index;
      logic [BYTE_W-1:0]    data_byte;
   } rsp_data_type;

endpackage

`default_nettype wire

>>> rtl/sync_header_frame_parser_core.sv
// Sync-header frame parser: byte phase machine plus a one-deep result register.
// Depends on shfp_pkg for constants and the result payload layout.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   req channel: one transfer per received byte. tdata[7:0] is the byte; tuser
//   is the mode (0 = byte, 1 = forget the previous serial so the next frame's
//   serial is not checked).
//   rsp channel: tuser is the kind (0 = payload byte, 1 = frame header). A
//   payload result carries the byte and its index; a header result carries all
//   header fields, the checksum and the status flags when the frame ends.
//   csr: csr_wr_en writes csr_wr_data into min_version (reset value 1).
// Timing: the phase machine and all header registers update in the cycle a
//   byte is taken; a result is on rsp in the cycle after its byte was taken.
//   One byte per cycle unless stalled; the result register is the only buffer.
// Stall: while a result waits in the result register and the receiver is not
//   ready, req_tready is low. Bytes that give no result still wait for it.
// Reset (synchronous): hunting for the first sync byte, result register empty,
//   first frame after reset is exempt from the serial check.
module sync_header_frame_parser_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input byte channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] mode
   // Result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [shfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [7:0] data_byte, [18:8] data_index, [34:19] sender_version,
   // [46:35] data_length, [54:47] frame serial, [70:55] feature_address,
   // [78:71] command byte, [86:79] transfer_mode, [118:87] checksum_value,
   // [121:119] status_flags, [127:122] zero
   output logic             rsp_tuser,   // [0] kind
   // Configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data  // min_version
);
   import shfp_pkg::*;

   // Phase codes
   localparam logic [3:0] PH_HUNT     = 4'd0;
   localparam logic [3:0] PH_SYNC_B   = 4'd1;
   localparam logic [3:0] PH_VER_LO   = 4'd2;
   localparam logic [3:0] PH_VER_HI   = 4'd3;
   localparam logic [3:0] PH_LEN_LO   = 4'd4;
   localparam logic [3:0] PH_LEN_HI   = 4'd5;
   localparam logic [3:0] PH_SERIAL   = 4'd6;
   localparam logic [3:0] PH_FEAT_LO  = 4'd7;
   localparam logic [3:0] PH_FEAT_HI  = 4'd8;
   localparam logic [3:0] PH_REQUEST  = 4'd9;
   localparam logic [3:0] PH_MODE     = 4'd10;
   localparam logic [3:0] PH_PAYLOAD  = 4'd11;
   localparam logic [3:0] PH_CRC0     = 4'd12;
   localparam logic [3:0] PH_CRC1     = 4'd13;
   localparam logic [3:0] PH_CRC2     = 4'd14;
   localparam logic [3:0] PH_CRC3     = 4'd15;

   // Parser state
   logic [3:0]           phase_ff, phase_in;
   logic [VERSION_W-1:0] version_ff, version_in;
   logic [LENGTH_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0]    len_lo_ff, len_lo_in;
   logic [BYTE_W-1:0]    serial_ff, serial_in;
   logic [VERSION_W-1:0] feature_ff, feature_in;
   logic [BYTE_W-1:0]    request_ff, request_in;
   logic [BYTE_W-1:0]    hmode_ff, hmode_in;
   logic [INDEX_W-1:0]   count_ff, count_in;
   logic [CRC_W-1:0]     crc_ff, crc_in;
   logic [FLAGS_W-1:0]   flags_ff, flags_in;
   logic [BYTE_W-1:0]    prev_serial_ff, prev_serial_in;
   logic                 first_ff, first_in;
   logic [15:0]          min_version_ff;

   // Result register
   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff, rsp_kind_in;
   rsp_data_type         rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 emit;
   logic [BYTE_W-1:0]    rx;
   logic [15:0]          full_len;
   logic [LENGTH_W-1:0]  count_next;
   logic [BYTE_W-1:0]    serial_expect;

   assign req_tready    = !rsp_valid_ff || rsp_tready;
   assign accept        = req_tvalid && req_tready;
   assign rx            = req_tdata;
   assign full_len      = {rx, len_lo_ff};
   assign count_next    = {1'b0, count_ff} + LENGTH_W'(1);
   assign serial_expect = (prev_serial_ff + 8'd1) & SERIAL_MOD_MASK;

   // Next state and result for the byte on the input
   always_comb begin
      phase_in       = phase_ff;
      version_in     = version_ff;
      length_in      = length_ff;
      len_lo_in      = len_lo_ff;
      serial_in      = serial_ff;
      feature_in     = feature_ff;
      request_in     = request_ff;
      hmode_in       = hmode_ff;
      count_in       = count_ff;
      crc_in         = crc_ff;
      flags_in       = flags_ff;
      prev_serial_in = prev_serial_ff;
      first_in       = first_ff;
      emit           = 1'b0;
      rsp_kind_in    = KIND_DATA;
      rsp_data_in    = '0;

      if (req_tuser == MODE_FORGET_SERIAL) begin
         first_in = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_HUNT: begin
               flags_in = '0;
               if (rx == SYNC_A) phase_in = PH_SYNC_B;
            end
            PH_SYNC_B: begin
               phase_in = (rx == SYNC_B) ? PH_VER_LO : PH_HUNT;
            end
            PH_VER_LO: begin
               version_in = {8'd0, rx};
               phase_in   = PH_VER_HI;
            end
            PH_VER_HI: begin
               version_in = {rx, version_ff[7:0]};
               if ({rx, version_ff[7:0]} < min_version_ff) flags_in[FLAG_VERSION] = 1'b1;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_lo_in = rx;
               phase_in  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               // Oversized frames are dropped without a result
               length_in = full_len[LENGTH_W-1:0];
               phase_in  = (full_len > MAX_DATA) ? PH_HUNT : PH_SERIAL;
            end
            PH_SERIAL: begin
               serial_in = rx;
               if (first_ff) first_in = 1'b0;
               else if (rx != serial_expect) flags_in[FLAG_SERIAL] = 1'b1;
               prev_serial_in = rx;
               phase_in       = PH_FEAT_LO;
            end
            PH_FEAT_LO: begin
               feature_in = {8'd0, rx};
               phase_in   = PH_FEAT_HI;
            end
            PH_FEAT_HI: begin
               feature_in = {rx, feature_ff[7:0]};
               phase_in   = PH_REQUEST;
            end
            PH_REQUEST: begin
               request_in = rx;
               phase_in   = PH_MODE;
            end
            PH_MODE: begin
               hmode_in = rx;
               crc_in   = '0;
               count_in = '0;
               if (length_ff != '0) phase_in = PH_PAYLOAD;
               else if (rx[0])      phase_in = PH_CRC0;
               else begin
                  emit        = 1'b1;
                  rsp_kind_in = KIND_HEADER;
                  phase_in    = PH_HUNT;
               end
            end
            PH_PAYLOAD: begin
               count_in              = count_next[INDEX_W-1:0];
               emit                  = 1'b1;
               rsp_data_in.data_byte  = rx;
               rsp_data_in.data_index = count_ff;
               if (count_next >= length_ff) begin
                  if (hmode_ff[0]) phase_in = PH_CRC0;
                  else begin
                     // last payload byte closes the frame: header carries it
                     rsp_kind_in = KIND_HEADER;
                     phase_in    = PH_HUNT;
                  end
               end
            end
            PH_CRC0: begin
               crc_in   = {24'd0, rx};
               phase_in = PH_CRC1;
            end
            PH_CRC1: begin
               crc_in   = {crc_ff[31:16], rx, crc_ff[7:0]};
               phase_in = PH_CRC2;
            end
            PH_CRC2: begin
               crc_in   = {crc_ff[31:24], rx, crc_ff[15:0]};
               phase_in = PH_CRC3;
            end
            PH_CRC3: begin
               crc_in                  = {rx, crc_ff[23:0]};
               flags_in[FLAG_CHECKSUM] = 1'b1;
               emit                    = 1'b1;
               rsp_kind_in             = KIND_HEADER;
               phase_in                = PH_HUNT;
            end
            default: phase_in = PH_HUNT;
         endcase
      end

      // Header fields are filled only in header results
      if (rsp_kind_in == KIND_HEADER) begin
         rsp_data_in.sender_version  = version_in;
         rsp_data_in.data_length     = length_in;
         rsp_data_in.frame_serial    = serial_in;
         rsp_data_in.feature_address = feature_in;
         rsp_data_in.command_byte    = request_in;
         rsp_data_in.transfer_mode   = hmode_in;
         rsp_data_in.checksum_value  = hmode_in[0] ? crc_in : '0;
         rsp_data_in.status_flags    = flags_in;
      end
   end

   // Parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         version_ff     <= '0;
         length_ff      <= '0;
         len_lo_ff      <= '0;
         serial_ff      <= '0;
         feature_ff     <= '0;
         request_ff     <= '0;
         hmode_ff       <= '0;
         count_ff       <= '0;
         crc_ff         <= '0;
         flags_ff       <= '0;
         prev_serial_ff <= '0;
         first_ff       <= 1'b1;
      end else if (accept) begin
         phase_ff       <= phase_in;
         version_ff     <= version_in;
         length_ff      <= length_in;
         len_lo_ff      <= len_lo_in;
         serial_ff      <= serial_in;
         feature_ff     <= feature_in;
         request_ff     <= request_in;
         hmode_ff       <= hmode_in;
         count_ff       <= count_in;
         crc_ff         <= crc_in;
         flags_ff       <= flags_in;
         prev_serial_ff <= prev_serial_in;
         first_ff       <= first_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_version_ff <= 16'd1;
      end else if (csr_wr_en) begin
         min_version_ff <= csr_wr_data;
      end
   end

   // Result register: loaded on a byte that gives a result, freed on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // Payload results never carry header fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DATA |-> rsp_tdata[121:19] == '0)
      else $error("payload result carries header fields");

   // A header with a checksum always reports it as unverified
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_HEADER && rsp_data_ff.transfer_mode[0]
      |-> rsp_data_ff.status_flags[FLAG_CHECKSUM])
      else $error("checksum present but flag clear");

   // A header result always leaves the parser hunting for the next frame
   assert property (@(posedge clock) disable iff (reset)
      accept && emit && rsp_kind_in == KIND_HEADER |=> phase_ff == PH_HUNT)
      else $error("parser not hunting after frame end");

   // Reset returns the parser to hunting with the result register empty
   assert property (@(posedge clock)
      reset |=> phase_ff == PH_HUNT && !rsp_tvalid)
      else $error("reset state wrong");
`endif

endmodule

`default_nettype wire

>>> tb/sync_header_frame_parser_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sync_header_frame_parser_core: directed frames, then random traffic.
// Depends on shfp_pkg and the parser core; a built-in parser predictor checks every result.

module sync_header_frame_parser_core_tb;
   import shfp_pkg::*;

   // Expected result: kind plus payload, same layout as rsp_tuser/rsp_tdata
   typedef struct packed {
      logic         kind;
      rsp_data_type data;
   } frame_result_type;

   // Predictor phase of the frame parser
   typedef enum logic [3:0] {
      HUNT_SYNC_A, HUNT_SYNC_B, VERSION_LO, VERSION_HI, LENGTH_LO, LENGTH_HI,
      SERIAL_NUM, FEATURE_LO, FEATURE_HI, REQUEST_BYTE, XFER_MODE, PAYLOAD,
      CRC_B0, CRC_B1, CRC_B2, CRC_B3
   } parse_phase_type;

   // Directed stimulus row; typed rows carry a hand-written expectation
   typedef struct packed {
      logic       mode;
      logic [7:0] rx;
      logic       typed;
   } stim_row_type;

   localparam int DIRECTED_N = 36;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = 8'h00;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [15:0]           csr_wr_data = 16'h0000;

   // Predictor state and configuration
   parse_phase_type prs_phase  = HUNT_SYNC_A;
   logic [15:0]  hv_version    = '0;
   logic [15:0]  hv_length     = '0;
   logic [7:0]   hv_serial     = '0;
   logic [15:0]  hv_feature    = '0;
   logic [7:0]   hv_request    = '0;
   logic [7:0]   hv_mode       = '0;
   logic [15:0]  pay_count     = '0;
   logic [31:0]  crc_sum       = '0;
   logic [2:0]   status_bits   = '0;
   logic [7:0]   prev_ser      = '0;
   logic         serial_exempt = 1'b1;
   logic [15:0]  min_ver       = 16'd1;

   frame_result_type expected_results[$];
   frame_result_type typed_results[2];
   int            mismatch_count = 0;
   int            item_count     = 0;
   int            send_gap_pct   = 0;
   int            rsp_stall_pct  = 0;
   logic [7:0]    gen_serial     = 8'h00;

   // Frames: bad second sync, oversize length, zero-length frame with checksum,
   // forget-serial, one-byte frame ending on its payload byte
   stim_row_type directed_rows [DIRECTED_N] = '{
      '{MODE_BYTE, SYNC_A, 1'b0}, '{MODE_BYTE, SYNC_A, 1'b0},
      '{MODE_BYTE, SYNC_A, 1'b0}, '{MODE_BYTE, SYNC_B, 1'b0},
      '{MODE_BYTE, 8'h00, 1'b0},  '{MODE_BYTE, 8'h00, 1'b0},
      '{MODE_BYTE, 8'h01, 1'b0},  '{MODE_BYTE, 8'h08, 1'b0},
      '{MODE_BYTE, SYNC_A, 1'b0}, '{MODE_BYTE, SYNC_B, 1'b0},
      '{MODE_BYTE, 8'h00, 1'b0},  '{MODE_BYTE, 8'h00, 1'b0},
      '{MODE_BYTE, 8'h00, 1'b0},  '{MODE_BYTE, 8'h00, 1'b0},
      '{MODE_BYTE, 8'hFF, 1'b0},  '{MODE_BYTE, 8'hFF, 1'b0},
      '{MODE_BYTE, 8'hFF, 1'b0},  '{MODE_BYTE, 8'hFF, 1'b0},
      '{MODE_BYTE, 8'hFF, 1'b0},  '{MODE_BYTE, 8'h78, 1'b0},
      '{MODE_BYTE, 8'h56, 1'b0},  '{MODE_BYTE, 8'h34, 1'b0},
      '{MODE_BYTE, 8'h12, 1'b1},  '{MODE_FORGET_SERIAL, 8'hFF, 1'b0},
      '{MODE_BYTE, SYNC_A, 1'b0}, '{MODE_BYTE, SYNC_B, 1'b0},
      '{MODE_BYTE, 8'hFF, 1'b0},  '{MODE_BYTE, 8'hFF, 1'b0},
      '{MODE_BYTE, 8'h01, 1'b0},  '{MODE_BYTE, 8'h00, 1'b0},
      '{MODE_BYTE, 8'h05, 1'b0},  '{MODE_BYTE, 8'h00, 1'b0},
      '{MODE_BYTE, 8'h00, 1'b0},  '{MODE_BYTE, 8'h00, 1'b0},
      '{MODE_BYTE, 8'hFE, 1'b0},  '{MODE_BYTE, 8'hAB, 1'b1}
   };

   sync_header_frame_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Random receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic frame_result_type header_result(
      input logic [15:0] ver, input logic [11:0] len, input logic [7:0] ser,
      input logic [15:0] feat, input logic [7:0] reqc, input logic [7:0] xmode,
      input logic [31:0] crc, input logic [2:0] flags, input logic [7:0] last_byte,
      input logic [10:0] last_index);
      frame_result_type r;
      r = '0;
      r.kind                 = KIND_HEADER;
      r.data.data_byte       = last_byte;
      r.data.data_index      = last_index;
      r.data.sender_version  = ver;
      r.data.data_length     = len;
      r.data.frame_serial    = ser;
      r.data.feature_address = feat;
      r.data.command_byte    = reqc;
      r.data.transfer_mode   = xmode;
      r.data.checksum_value  = crc;
      r.data.status_flags    = flags;
      return r;
   endfunction

   // Header result for the frame held in the predictor
   function automatic frame_result_type frame_header(input logic [7:0] last_byte,
                                                     input logic [10:0] last_index);
      return header_result(hv_version, hv_length[11:0], hv_serial, hv_feature, hv_request,
                           hv_mode, hv_mode[0] ? crc_sum : 32'h0, status_bits,
                           last_byte, last_index);
   endfunction

   // Predict the parser's reaction to one accepted byte
   task automatic advance_parser(input logic mode, input logic [7:0] b,
                                 output bit emitted, output frame_result_type res);
      logic [15:0] idx;
      emitted = 1'b0;
      res     = '0;
      if (mode == MODE_FORGET_SERIAL) begin
         serial_exempt = 1'b1;
      end else begin
         case (prs_phase)
            HUNT_SYNC_A: begin
               status_bits = '0;
               if (b == SYNC_A) prs_phase = HUNT_SYNC_B;
            end
            HUNT_SYNC_B: prs_phase = (b == SYNC_B) ? VERSION_LO : HUNT_SYNC_A;
            VERSION_LO: begin
               hv_version = {8'h00, b};
               prs_phase  = VERSION_HI;
            end
            VERSION_HI: begin
               hv_version[15:8] = b;
               if (hv_version < min_ver) status_bits[FLAG_VERSION] = 1'b1;
               prs_phase = LENGTH_LO;
            end
            LENGTH_LO: begin
               hv_length = {8'h00, b};
               prs_phase = LENGTH_HI;
            end
            LENGTH_HI: begin
               hv_length[15:8] = b;
               // oversize frames vanish without a result
               prs_phase = (hv_length > MAX_DATA) ? HUNT_SYNC_A : SERIAL_NUM;
            end
            SERIAL_NUM: begin
               hv_serial = b;
               if (serial_exempt) serial_exempt = 1'b0;
               else if (b != ((prev_ser + 8'd1) & SERIAL_MOD_MASK))
                  status_bits[FLAG_SERIAL] = 1'b1;
               prev_ser  = b;
               prs_phase = FEATURE_LO;
            end
            FEATURE_LO: begin
               hv_feature = {8'h00, b};
               prs_phase  = FEATURE_HI;
            end
            FEATURE_HI: begin
               hv_feature[15:8] = b;
               prs_phase        = REQUEST_BYTE;
            end
            REQUEST_BYTE: begin
               hv_request = b;
               prs_phase  = XFER_MODE;
            end
            XFER_MODE: begin
               hv_mode   = b;
               crc_sum   = '0;
               pay_count = '0;
               if (hv_length != 16'd0) prs_phase = PAYLOAD;
               else if (b[0]) prs_phase = CRC_B0;
               else begin
                  emitted   = 1'b1;
                  res       = frame_header(8'h00, 11'd0);
                  prs_phase = HUNT_SYNC_A;
               end
            end
            PAYLOAD: begin
               idx                  = pay_count;
               pay_count            = pay_count + 16'd1;
               emitted              = 1'b1;
               res.kind             = KIND_DATA;
               res.data.data_byte   = b;
               res.data.data_index  = idx[10:0];
               if (pay_count >= hv_length) begin
                  if (hv_mode[0]) prs_phase = CRC_B0;
                  else begin
                     // last payload byte rides on the header result
                     res       = frame_header(b, idx[10:0]);
                     prs_phase = HUNT_SYNC_A;
                  end
               end
            end
            CRC_B0: begin
               crc_sum   = {24'h0, b};
               prs_phase = CRC_B1;
            end
            CRC_B1: begin
               crc_sum[15:8] = b;
               prs_phase     = CRC_B2;
            end
            CRC_B2: begin
               crc_sum[23:16] = b;
               prs_phase      = CRC_B3;
            end
            CRC_B3: begin
               crc_sum[31:24]             = b;
               status_bits[FLAG_CHECKSUM] = 1'b1;
               emitted                    = 1'b1;
               res                        = frame_header(8'h00, 11'd0);
               prs_phase                  = HUNT_SYNC_A;
            end
         endcase
      end
   endtask

   // One input transfer, with random idle cycles ahead of it
   task automatic send_item(input logic mode, input logic [7:0] rx, input bit use_typed,
                            input frame_result_type typed_res);
      bit               emitted;
      frame_result_type res;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_parser(mode, rx, emitted, res);
      if (use_typed) expected_results.push_back(typed_res);
      else if (emitted) expected_results.push_back(res);
      item_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(MODE_BYTE, b, 1'b0, '0);
   endtask

   // Frame with random content, sometimes with an oversize length; mostly short payloads
   task automatic send_random_frame();
      logic [15:0] len, ver, feat;
      logic [7:0]  ser, xmode;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 65) len = 16'($urandom_range(8));
      else if (pick < 90) len = 16'($urandom_range(40, 9));
      else if (pick < 95) len = MAX_DATA + 16'd1;
      else len = 16'($urandom_range(65535, 2049));
      case ($urandom_range(3))
         0:       ver = min_ver - 16'd1;
         1:       ver = min_ver;
         default: ver = 16'($urandom());
      endcase
      ser   = ($urandom_range(3) != 0) ? ((gen_serial + 8'd1) & SERIAL_MOD_MASK)
                                       : 8'($urandom());
      feat  = 16'($urandom());
      xmode = 8'($urandom());
      send_byte(SYNC_A);
      send_byte(SYNC_B);
      send_byte(ver[7:0]);
      send_byte(ver[15:8]);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      if (len <= MAX_DATA) begin
         if ($urandom_range(19) == 0) send_item(MODE_FORGET_SERIAL, 8'($urandom()), 1'b0, '0);
         gen_serial = ser;
         send_byte(ser);
         send_byte(feat[7:0]);
         send_byte(feat[15:8]);
         send_byte(8'($urandom()));
         send_byte(xmode);
         for (int i = 0; i < int'(len); i++) send_byte(8'($urandom()));
         if (xmode[0]) repeat (4) send_byte(8'($urandom()));
      end
   endtask

   // Drain all results, let the core settle, then write min_version
   task automatic write_min_version(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      min_ver = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (got_v !== exp_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: %s expected %h got %h", name, exp_v, got_v);
      end
   endtask

   task automatic compare_result(input frame_result_type exp, input logic got_kind,
                                 input rsp_data_type got);
      check_field("kind", 32'(exp.kind), 32'(got_kind));
      check_field("data_byte", 32'(exp.data.data_byte), 32'(got.data_byte));
      check_field("data_index", 32'(exp.data.data_index), 32'(got.data_index));
      check_field("sender_version", 32'(exp.data.sender_version), 32'(got.sender_version));
      check_field("data_length", 32'(exp.data.data_length), 32'(got.data_length));
      check_field("frame_serial", 32'(exp.data.frame_serial), 32'(got.frame_serial));
      check_field("feature_address", 32'(exp.data.feature_address),
                  32'(got.feature_address));
      check_field("command_byte", 32'(exp.data.command_byte), 32'(got.command_byte));
      check_field("transfer_mode", 32'(exp.data.transfer_mode), 32'(got.transfer_mode));
      check_field("checksum_value", exp.data.checksum_value, got.checksum_value);
      check_field("status_flags", 32'(exp.data.status_flags), 32'(got.status_flags));
      check_field("pad", 32'(exp.data.pad), 32'(got.pad));
   endtask

   // Result monitor: every rsp transfer is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: unexpected result kind %b data %h", rsp_tuser, rsp_tdata);
         end else begin
            compare_result(expected_results.pop_front(), rsp_tuser, rsp_data_type'(rsp_tdata));
         end
      end
   end

   // Stimulus
   initial begin
      int          typed_idx;
      int          target;
      int          pick;
      logic [7:0]  b;
      logic [2:0]  flags_a;
      int          gap_pcts   [4];
      int          stall_pcts [4];
      logic [15:0] versions   [4];
      typed_idx  = 0;
      gap_pcts   = '{0, 71, 0, 21};
      stall_pcts = '{0, 0, 71, 21};
      versions   = '{16'h0000, 16'hFFFF, 16'($urandom()), 16'h8000};
      flags_a    = '0;
      flags_a[FLAG_VERSION]  = 1'b1;
      flags_a[FLAG_CHECKSUM] = 1'b1;
      typed_results[0] = header_result(16'h0000, 12'd0, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF,
                                       32'h12345678, flags_a, 8'h00, 11'd0);
      typed_results[1] = header_result(16'hFFFF, 12'd1, 8'h05, 16'h0000, 8'h00, 8'hFE,
                                       32'h0, 3'b000, 8'hAB, 11'd0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int r = 0; r < DIRECTED_N; r++) begin
         if (directed_rows[r].typed) begin
            send_item(directed_rows[r].mode, directed_rows[r].rx, 1'b1,
                      typed_results[typed_idx]);
            typed_idx++;
         end else begin
            send_item(directed_rows[r].mode, directed_rows[r].rx, 1'b0, '0);
         end
      end

      // Random phases, each with its own min_version and idle pattern
      for (int p = 0; p < 4; p++) begin
         write_min_version(versions[p]);
         send_gap_pct = gap_pcts[p];
         rsp_stall_pct <= stall_pcts[p];
         target = item_count + 312;
         while (item_count < target) begin
            pick = $urandom_range(99);
            if (pick < 75) send_random_frame();
            else if (pick < 85) begin
               // line noise, biased toward the first sync byte
               repeat ($urandom_range(6, 1))
                  send_byte(($urandom_range(3) == 0) ? SYNC_A : 8'($urandom()));
            end else if (pick < 92) begin
               // first sync byte followed by anything but the second
               b = 8'($urandom());
               if (b == SYNC_B) b = SYNC_A;
               send_byte(SYNC_A);
               send_byte(b);
            end else begin
               send_item(MODE_FORGET_SERIAL, 8'($urandom()), 1'b0, '0);
            end
         end
      end

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

>>> sync_header_frame_parser_core.f
rtl/shfp_pkg.sv
rtl/sync_header_frame_parser_core.sv
tb/sync_header_frame_parser_core_tb.sv
